// ----- design/art_pkg.sv -----
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, codes and defaults for the allocation record table.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned TableDepthDef = 64;

  // operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_ZERO_ADDR = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
    logic [31:0] byte_size;
    logic [3:0]  source;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [6:0]  live_entries;
    logic [31:0] live_bytes;
  } rsp_t;

  // one stored record
  typedef struct packed {
    logic        valid;
    logic [3:0]  source;
    logic [31:0] byte_size;
    logic [31:0] address;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic zero_addr;
    logic done;
  } ctl_sts_t;

endpackage

// ----- design/allocation_record_table.sv -----
// ----------------------------------------------------------------------------
// allocation_record_table
// Table of allocation records with add and remove requests.
// ----------------------------------------------------------------------------
// After reset the block sweeps the record memory once to clear every valid
// flag, one slot per cycle, with in_ready_o held low until the sweep ends.
// It then takes one request beat at a time. An add stores address, size and
// source in the lowest free slot; a remove frees the lowest valid slot whose
// address and source match. Both walk the record memory one slot per cycle
// through its single registered read port, so a full table or a failed
// remove walks every slot. A zero address is answered without touching the
// table. Each result carries the live record count and the live byte total
// (mod 2^32). The result sits in an output register; the next request is
// taken as soon as the result has moved there, even while it still waits
// for out_ready_i.
// ----------------------------------------------------------------------------
module allocation_record_table import art_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request channel
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  // result channel
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer: owns both handshakes
  art_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // record memory, scan, totals and result registers
  art_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- design/art_ram.sv -----
// ----------------------------------------------------------------------------
// art_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module art_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/art_datapath.sv -----
// ----------------------------------------------------------------------------
// art_datapath
// Request register, record memory, slot scan pipeline, totals and result.
// ----------------------------------------------------------------------------
module art_datapath import art_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ctl_cmd_t cmd_i,
  output ctl_sts_t sts_o,
  input  req_t     in_data_i,
  output rsp_t     out_data_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IdxW:0]   DepthVal = (IdxW + 1)'(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(TABLE_DEPTH - 1);

  req_t            req_q;
  logic [IdxW:0]   idx_q;
  logic            chk_q;
  logic [IdxW-1:0] chk_idx_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     bytes_q, bytes_d;
  rsp_t            res_q;
  rsp_t            out_q;

  entry_t          rd_entry;
  entry_t          wr_entry;
  logic            rd_en;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic            match;
  logic            hit;
  logic            miss_end;
  logic [IdxW+5:0] slot_ext;
  logic [CntW+6:0] live_ext_d;
  logic [CntW+6:0] live_ext_q;

  assign rd_en    = cmd_i.scan && (idx_q < DepthVal);
  assign match    = (req_q.operation == OP_ADD) ? !rd_entry.valid
                  : (rd_entry.valid && rd_entry.address == req_q.address
                     && rd_entry.source == req_q.source);
  assign hit      = cmd_i.scan && chk_q && match;
  assign miss_end = cmd_i.scan && chk_q && !match && (chk_idx_q == LastIdx);

  assign sts_o.done       = hit || miss_end;
  assign sts_o.clear_last = (idx_q[IdxW-1:0] == LastIdx);
  assign sts_o.zero_addr  = (in_data_i.address == 32'd0);

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (hit) begin
      if (req_q.operation == OP_ADD) begin
        cnt_d   = cnt_q + CntW'(1);
        bytes_d = bytes_q + req_q.byte_size;
      end else begin
        cnt_d   = cnt_q - CntW'(1);
        bytes_d = bytes_q - rd_entry.byte_size;
      end
    end
  end

  always_comb begin
    wr_entry = rd_entry;
    wr_addr  = chk_idx_q;
    if (cmd_i.clear) begin
      wr_entry = '0;
      wr_addr  = idx_q[IdxW-1:0];
    end else if (req_q.operation == OP_ADD) begin
      wr_entry.valid     = 1'b1;
      wr_entry.source    = req_q.source;
      wr_entry.byte_size = req_q.byte_size;
      wr_entry.address   = req_q.address;
    end else begin
      wr_entry.valid = 1'b0;
    end
  end

  assign wr_en = cmd_i.clear || hit;

  assign slot_ext   = {6'b0, chk_idx_q};
  assign live_ext_d = {7'b0, cnt_d};
  assign live_ext_q = {7'b0, cnt_q};

  art_ram #(
    .Width ($bits(entry_t)),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // scan index and check pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      chk_q     <= 1'b0;
      chk_idx_q <= '0;
      cnt_q     <= '0;
      bytes_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        chk_q <= 1'b0;
      end else if (cmd_i.clear || rd_en) begin
        idx_q <= idx_q + (IdxW + 1)'(1);
      end
      if (cmd_i.scan) begin
        chk_q <= rd_en;
      end
      if (rd_en) begin
        chk_idx_q <= idx_q[IdxW-1:0];
      end
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.load && sts_o.zero_addr) begin
      res_q.status       <= ST_ZERO_ADDR;
      res_q.slot         <= '0;
      res_q.live_entries <= live_ext_q[6:0];
      res_q.live_bytes   <= bytes_q;
    end else if (hit) begin
      res_q.status       <= ST_OK;
      res_q.slot         <= slot_ext[5:0];
      res_q.live_entries <= live_ext_d[6:0];
      res_q.live_bytes   <= bytes_d;
    end else if (miss_end) begin
      res_q.status       <= (req_q.operation == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
      res_q.slot         <= '0;
      res_q.live_entries <= live_ext_q[6:0];
      res_q.live_bytes   <= bytes_q;
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- design/art_ctrl.sv -----
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: clearing pass, request accept, scan, result hand-off.
// ----------------------------------------------------------------------------
module art_ctrl import art_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_POST  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.zero_addr ? S_POST : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.done) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/art_checker.sv -----
// ----------------------------------------------------------------------------
// art_checker
// Port-level checks for the allocation record table.
// ----------------------------------------------------------------------------
module art_checker import art_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // failed requests report slot zero
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.slot == 6'd0)
    else $error("nonzero slot on failed request");

  // one request in flight: no accept right after an accept
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // a new result only appears after the request side was busy
  a_rsp_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in flight");

endmodule

bind allocation_record_table art_checker u_art_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for allocation_record_table. A driver process sends
// add and remove beats from a backlog queue and a shadow table predicts each
// result. A monitor process compares every result beat with the oldest
// prediction. Both sides idle at random. The receiver also holds off once for
// a long stretch, and the sender drains between stimulus phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam int TableDepth   = TableDepthDef;
  localparam int RandItems    = 1200;
  localparam int RxHoldCycles = 500;      // long receiver back-pressure
  localparam int LimitCycles  = 1000000;  // far above the slowest legal run

  // (address, source) pair that a remove has to match
  typedef struct packed {
    logic [31:0] address;
    logic [3:0]  source;
  } tag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  req_t req_backlog_q[$];    // beats waiting to be offered
  rsp_t pending_rsp_q[$];    // predicted results, oldest first
  tag_t live_tags_q[$];      // generator's view of the records in the table

  // shadow copy of the record table
  logic        rec_valid[TableDepth];
  logic [31:0] rec_addr[TableDepth];
  logic [31:0] rec_size[TableDepth];
  logic [3:0]  rec_src[TableDepth];
  int          rec_count = 0;
  logic [31:0] rec_bytes = '0;

  int   n_accepted = 0;
  int   n_results = 0;
  int   n_mismatch = 0;
  int   n_cycles = 0;
  int   rx_hold_cnt = 0;
  logic rx_hold = 1'b0;
  logic rx_hold_done = 1'b0;
  logic calm;

  // window with no idling on either side
  assign calm = (n_accepted >= 500) && (n_accepted < 750);

  allocation_record_table DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one request to the shadow table and return the result it yields.
  // Adds take the lowest free slot, removes free the lowest matching one.
  function automatic rsp_t table_apply(req_t r);
    rsp_t res;
    int   hit;
    res = '0;
    hit = -1;
    if (r.address == '0) begin
      res.status = ST_ZERO_ADDR;
    end else if (r.operation == OP_ADD) begin
      for (int i = 0; i < TableDepth; i++)
        if (hit < 0 && !rec_valid[i]) hit = i;
      if (hit < 0) begin
        res.status = ST_FULL;
      end else begin
        rec_valid[hit] = 1'b1;
        rec_addr[hit]  = r.address;
        rec_size[hit]  = r.byte_size;
        rec_src[hit]   = r.source;
        rec_count++;
        rec_bytes      = rec_bytes + r.byte_size;   // wraps mod 2^32
        res.status     = ST_OK;
        res.slot       = 6'(hit);
      end
    end else begin
      for (int i = 0; i < TableDepth; i++)
        if (hit < 0 && rec_valid[i] && rec_addr[i] == r.address && rec_src[i] == r.source)
          hit = i;
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        rec_valid[hit] = 1'b0;
        rec_count--;
        rec_bytes      = rec_bytes - rec_size[hit];
        res.status     = ST_OK;
        res.slot       = 6'(hit);
      end
    end
    res.live_entries = 7'(rec_count);
    res.live_bytes   = rec_bytes;
    return res;
  endfunction

  // Addresses: some zero, many from a tiny pool so that duplicates collide,
  // the rest spread over all 32 bits.
  function automatic logic [31:0] pick_address();
    int          r;
    logic [31:0] a;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 35) return 32'($urandom_range(6, 1));
    a = $urandom;
    return (a == '0) ? 32'h1 : a;
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'hFFFF_FFFF - 32'($urandom_range(3));
    if (r < 40) return 32'($urandom_range(4096));
    return $urandom;
  endfunction

  // One random request. Most removes target a record believed to be live,
  // a few of those with a wrong source, the rest use a random address.
  function automatic req_t make_request(int add_pct);
    req_t r;
    int   idx;
    r.byte_size = pick_size();
    r.source    = 4'($urandom_range(15));
    if ($urandom_range(99) < add_pct) begin
      r.operation = OP_ADD;
      r.address   = pick_address();
      if (r.address != '0 && live_tags_q.size() < TableDepth)
        live_tags_q.push_back('{r.address, r.source});
    end else begin
      r.operation = OP_REMOVE;
      if (live_tags_q.size() != 0 && $urandom_range(99) < 85) begin
        idx       = $urandom_range(live_tags_q.size() - 1);
        r.address = live_tags_q[idx].address;
        r.source  = live_tags_q[idx].source;
        if ($urandom_range(9) == 0)
          r.source = r.source ^ 4'($urandom_range(15, 1));
        else
          live_tags_q.delete(idx);
      end else begin
        r.address = pick_address();
      end
    end
    return r;
  endfunction

  function automatic req_t mk(logic op, logic [31:0] a, logic [31:0] s, logic [3:0] src);
    req_t r;
    r.operation = op;
    r.address   = a;
    r.byte_size = s;
    r.source    = src;
    return r;
  endfunction

  // Sender pause: wait until every beat is sent and every result is back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_backlog_q.size() != 0 || in_valid || pending_rsp_q.size() != 0);
  endtask

  // Driver: one nonblocking update of valid/data per edge. A beat is
  // predicted at the edge that accepts it, so predictions follow accept order.
  always @(posedge clk_i) begin
    logic nxt_valid;
    req_t nxt_data;
    if (rst_ni) begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        pending_rsp_q.push_back(table_apply(in_data));
        n_accepted <= n_accepted + 1;
        nxt_valid = 1'b0;
      end
      // valid only drops after an accept, never while a beat is offered
      if (!nxt_valid && req_backlog_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
        nxt_data  = req_backlog_q.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Long receiver hold-off once traffic is under way; the sender keeps
  // offering, so the block fills its output register and stalls its input.
  always @(posedge clk_i) begin
    if (rst_ni && !rx_hold_done && n_accepted >= 60) begin
      if (rx_hold_cnt == RxHoldCycles) begin
        rx_hold      <= 1'b0;
        rx_hold_done <= 1'b1;
      end else begin
        rx_hold     <= 1'b1;
        rx_hold_cnt <= rx_hold_cnt + 1;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_rsp_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("[%0t] result beat %0d with nothing predicted: st=%0d slot=%0d live=%0d bytes=%h",
                     $realtime, n_results, out_data.status, out_data.slot,
                     out_data.live_entries, out_data.live_bytes);
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_data.status !== want.status || out_data.slot !== want.slot ||
              out_data.live_entries !== want.live_entries ||
              out_data.live_bytes !== want.live_bytes) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("[%0t] result beat %0d mismatch: exp st=%0d slot=%0d live=%0d bytes=%h",
                       $realtime, n_results, want.status, want.slot, want.live_entries,
                       want.live_bytes,
                       "  got st=%0d slot=%0d live=%0d bytes=%h",
                       out_data.status, out_data.slot, out_data.live_entries,
                       out_data.live_bytes);
          end
        end
      end
      out_ready <= !rx_hold && (calm || $urandom_range(99) >= 30);
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= LimitCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int phase;
    int len;
    int add_pct;
    for (int i = 0; i < TableDepth; i++) rec_valid[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero address on both operations, miss on an empty table,
    // extreme fields, byte total wrapping both ways, duplicate records,
    // source and address mismatch, lowest-slot reuse, drain to empty.
    req_backlog_q.push_back(mk(OP_ADD,    32'h0,         32'd5,         4'd3));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h0,         32'd0,         4'd0));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h1234,      32'd0,         4'd1));
    req_backlog_q.push_back(mk(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    req_backlog_q.push_back(mk(OP_ADD,    32'h1,         32'd2,         4'd0));
    req_backlog_q.push_back(mk(OP_ADD,    32'h8000_0000, 32'd0,         4'd8));
    req_backlog_q.push_back(mk(OP_ADD,    32'h1234,      32'd100,       4'd1));
    req_backlog_q.push_back(mk(OP_ADD,    32'h1234,      32'd200,       4'd1));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h1234,      32'hFFFF_FFFF, 4'd2));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h1235,      32'd0,         4'd1));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h1234,      32'd0,         4'd1));
    req_backlog_q.push_back(mk(OP_ADD,    32'h5555_AAAA, 32'hAAAA_5555, 4'd5));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'hFFFF_FFFF, 32'd0,         4'd15));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h1234,      32'd0,         4'd1));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h1234,      32'd0,         4'd1));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h1,         32'd0,         4'd0));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h8000_0000, 32'd0,         4'd8));
    req_backlog_q.push_back(mk(OP_REMOVE, 32'h5555_AAAA, 32'd0,         4'd5));
    wait_drained();

    // Random phases: fill (runs into table full), churn, drain. The sender
    // drains between phases, so every phase starts from a quiet block.
    n_rand = 0;
    phase  = 0;
    while (n_rand < RandItems) begin
      case (phase % 3)
        0: begin
          len     = 100;
          add_pct = 88;
        end
        1: begin
          len     = 80;
          add_pct = 50;
        end
        default: begin
          len     = 70;
          add_pct = 18;
        end
      endcase
      repeat (len) begin
        req_backlog_q.push_back(make_request(add_pct));
        n_rand++;
      end
      wait_drained();
      phase++;
    end

    // Let any stray result beat show up before judging.
    repeat (TableDepth + 16) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
